@@ rtl/pcmfc_pkg.sv @@
// ----------------------------------------------------------------------------
// pcmfc_pkg
// shared types, constants, depth conversion and the sequencer program rom
// ----------------------------------------------------------------------------
package pcmfc_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int RATE_W    = 19;
  localparam int CH_W      = 2;
  localparam int CFG_IDX_W = 3;
  localparam int PC_W      = 3;

  localparam logic [CH_W-1:0] CH_STEREO = 2'd2;

  typedef logic [PC_W-1:0] pc_t;

  // program steps
  localparam pc_t P_WAIT  = 3'd0;
  localparam pc_t P_MUL   = 3'd1;
  localparam pc_t P_DINIT = 3'd2;
  localparam pc_t P_DIV   = 3'd3;
  localparam pc_t P_END   = 3'd4;
  localparam pc_t P_RUN   = 3'd5;
  localparam pc_t P_EMIT  = 3'd6;
  localparam pc_t P_DONE  = 3'd7;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_MUL,
    OP_DIV_INIT,
    OP_DIV,
    OP_END,
    OP_RUN,
    OP_EMIT,
    OP_DONE
  } op_e;

  typedef enum logic [2:0] {
    J_NEVER,
    J_ALWAYS,
    J_NO_IN,
    J_LOOP,
    J_RUN_NONE,
    J_EMIT_WAIT
  } jump_e;

  typedef struct packed {
    op_e   op;
    jump_e jump;
    pc_t   target;
  } uword_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_CH   = 3'd0,
    REG_SRC_WIDE = 3'd1,
    REG_TGT_CH   = 3'd2,
    REG_TGT_WIDE = 3'd3,
    REG_SRC_RATE = 3'd4,
    REG_TGT_RATE = 3'd5
  } cfg_reg_e;

  // raw bits at source depth to raw bits at target depth
  function automatic logic [SAMPLE_W-1:0] depth_conv(logic [SAMPLE_W-1:0] v, logic sw,
                                                     logic tw);
    logic signed [SAMPLE_W:0] adj;
    logic [SAMPLE_W-1:0]      res;
    adj = $signed({v[SAMPLE_W-1], v}) + (v[SAMPLE_W-1] ? 17'sd255 : 17'sd0);
    if (sw && !tw) begin
      // truncating divide by 256, then offset by 128
      res = {8'h00, ~adj[15], adj[14:8]};
    end else if (!sw && tw) begin
      res = {~v[7], v[6:0], 8'h00};
    end else if (sw) begin
      res = v;
    end else begin
      res = {8'h00, v[7:0]};
    end
    return res;
  endfunction

  // program rom: one control word per step
  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    case (pc)
      P_WAIT:  w = '{op: OP_LOAD,     jump: J_NO_IN,     target: P_WAIT};
      P_MUL:   w = '{op: OP_MUL,      jump: J_LOOP,      target: P_MUL};
      P_DINIT: w = '{op: OP_DIV_INIT, jump: J_NEVER,     target: P_WAIT};
      P_DIV:   w = '{op: OP_DIV,      jump: J_LOOP,      target: P_DIV};
      P_END:   w = '{op: OP_END,      jump: J_NEVER,     target: P_WAIT};
      P_RUN:   w = '{op: OP_RUN,      jump: J_RUN_NONE,  target: P_DONE};
      P_EMIT:  w = '{op: OP_EMIT,     jump: J_EMIT_WAIT, target: P_EMIT};
      P_DONE:  w = '{op: OP_DONE,     jump: J_ALWAYS,    target: P_WAIT};
      default: w = '{op: OP_DONE,     jump: J_ALWAYS,    target: P_WAIT};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/pcmfc_if.sv @@
// ----------------------------------------------------------------------------
// pcmfc interfaces
// valid/ready channels for input frames, output frames and register writes
// ----------------------------------------------------------------------------
interface pcmfc_in_if;
  logic                          valid;
  logic                          ready;
  logic [pcmfc_pkg::SAMPLE_W-1:0] left_in;
  logic [pcmfc_pkg::SAMPLE_W-1:0] right_in;
  logic                          clip_end;

  modport source (output valid, left_in, right_in, clip_end, input ready);
  modport sink   (input valid, left_in, right_in, clip_end, output ready);
endinterface

interface pcmfc_out_if;
  logic                          valid;
  logic                          ready;
  logic [pcmfc_pkg::SAMPLE_W-1:0] left_out;
  logic [pcmfc_pkg::SAMPLE_W-1:0] right_out;
  logic                          run_last;
  logic                          clip_last;

  modport source (output valid, left_out, right_out, run_last, clip_last, input ready);
  modport sink   (input valid, left_out, right_out, run_last, clip_last, output ready);
endinterface

interface pcmfc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pcmfc_pkg::CFG_IDX_W-1:0] index;
  logic [pcmfc_pkg::RATE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/pcm_format_converter_top.sv @@
// ----------------------------------------------------------------------------
// pcm_format_converter_top
// pcm frame converter: channel count, sample depth and nearest-lower rate
// ----------------------------------------------------------------------------
// an input frame is taken only in the wait step; the sequencer then runs the
//   bit-serial 19-step multiply and the one-bit-per-cycle divider
//   (FRAME_COUNT_BITS + 20 steps), which share the sequencer datapath, and
//   then emits the run of results for that frame
// results leave one per cycle while the sink keeps ready high
// reset: rst_ni async active low; control and config registers to their reset values, clip cleared
module pcm_format_converter_top #(
  parameter int FRAME_COUNT_BITS = 32,
  parameter int MAX_RUN          = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pcmfc_cfg_if.sink     cfg_i,
  pcmfc_in_if.sink      src_i,
  pcmfc_out_if.source   res_o
);
  import pcmfc_pkg::*;

  // product / quotient width: (frame index + 1) times rate
  localparam int XW   = FRAME_COUNT_BITS + RATE_W + 1;
  localparam int CNTW = $clog2(XW);
  localparam int RUNW = $clog2(MAX_RUN + 1);

  // configuration registers
  logic [CH_W-1:0]   src_ch_q, tgt_ch_q;
  logic              src_wide_q, tgt_wide_q;
  logic [RATE_W-1:0] src_rate_q, tgt_rate_q;

  // sequencer
  pc_t    pc_q, pc_d;
  uword_t uw;
  logic   take_jump;
  logic [CNTW-1:0] cnt_q;

  // clip state
  logic [FRAME_COUNT_BITS-1:0] si_q;
  logic [XW-1:0]               emitted_q;

  // datapath
  logic [XW-1:0]       acc_q;     // product, then dividend / quotient
  logic [XW-1:0]       mcand_q;
  logic [RATE_W-1:0]   mplier_q;
  logic [RATE_W-1:0]   rem_q;
  logic [XW-1:0]       end_q;
  logic [SAMPLE_W-1:0] lo_q, ro_q;
  logic                last_q;
  logic [RUNW-1:0]     run_cnt_q;

  // output register
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] left_out_q, right_out_q;
  logic                run_last_q, clip_last_q;
  logic                slot_free;

  // effective rates, zero acts as one
  logic [RATE_W-1:0] irate, orate;
  assign irate = (src_rate_q == '0) ? RATE_W'(1) : src_rate_q;
  assign orate = (tgt_rate_q == '0) ? RATE_W'(1) : tgt_rate_q;

  logic s_st, t_st;
  assign s_st = (src_ch_q == CH_STEREO);
  assign t_st = (tgt_ch_q == CH_STEREO);

  // ---------------------------------------------------------------- samples
  // channel stage at source depth, then depth stage
  logic [SAMPLE_W-1:0]       l_m, r_m, l_c, r_c, avg16, lo_c, ro_c;
  logic signed [SAMPLE_W:0]  sum16, sum_adj;
  logic [8:0]                sum8;

  always_comb begin
    l_m     = src_wide_q ? src_i.left_in  : {8'h00, src_i.left_in[7:0]};
    r_m     = src_wide_q ? src_i.right_in : {8'h00, src_i.right_in[7:0]};
    // signed mean rounded toward zero
    sum16   = $signed({l_m[SAMPLE_W-1], l_m}) + $signed({r_m[SAMPLE_W-1], r_m});
    sum_adj = sum16 + $signed({{SAMPLE_W{1'b0}}, sum16[SAMPLE_W]});
    avg16   = sum_adj[SAMPLE_W:1];
    // unsigned floor mean
    sum8    = {1'b0, l_m[7:0]} + {1'b0, r_m[7:0]};
    if (!s_st) begin
      l_c = l_m;
      r_c = l_m;
    end else if (!t_st) begin
      l_c = src_wide_q ? avg16 : {8'h00, sum8[8:1]};
      r_c = r_m;
    end else begin
      l_c = l_m;
      r_c = r_m;
    end
    lo_c = depth_conv(l_c, src_wide_q, tgt_wide_q);
    ro_c = t_st ? depth_conv(r_c, src_wide_q, tgt_wide_q) : '0;
  end

  // ------------------------------------------------------------- arithmetic
  // restoring divide step
  logic [RATE_W:0] trial;
  logic            ge;
  assign trial = {rem_q, acc_q[XW-1]};
  assign ge    = (trial >= {1'b0, irate});

  // end index: ceil of the quotient, or the clip-end cap
  // cap = q + (r * fs > (fs - 1) * irate), fs a power of two
  logic [1:0]        lg_fs;
  logic [RATE_W+1:0] r_sc, thr;
  logic              inc;
  always_comb begin
    lg_fs = {1'b0, t_st} + {1'b0, tgt_wide_q};
    r_sc  = {2'b00, rem_q} << lg_fs;
    case (lg_fs)
      2'd0:    thr = '0;
      2'd1:    thr = {2'b00, irate};
      default: thr = {1'b0, irate, 1'b0} + {2'b00, irate};
    endcase
    inc = last_q ? (r_sc > thr) : (rem_q != '0);
  end

  // run length
  logic [XW-1:0]   diff;
  logic            run_none, run_big;
  logic [RUNW-1:0] run_n;
  assign run_none = (end_q <= emitted_q);
  assign diff     = end_q - emitted_q;
  assign run_big  = (diff > XW'(MAX_RUN));
  assign run_n    = run_big ? RUNW'(MAX_RUN) : diff[RUNW-1:0];

  assign slot_free = !out_valid_q || res_o.ready;

  // -------------------------------------------------------------- sequencer
  assign uw = ucode(pc_q);

  always_comb begin
    case (uw.jump)
      J_NEVER:     take_jump = 1'b0;
      J_ALWAYS:    take_jump = 1'b1;
      J_NO_IN:     take_jump = !src_i.valid;
      J_LOOP:      take_jump = (cnt_q != '0);
      J_RUN_NONE:  take_jump = run_none;
      J_EMIT_WAIT: take_jump = !(slot_free && (run_cnt_q == RUNW'(1)));
      default:     take_jump = 1'b0;
    endcase
    pc_d = take_jump ? uw.target : pc_q + pc_t'(1);
  end

  assign src_i.ready = (pc_q == P_WAIT);
  assign cfg_i.ready = (pc_q == P_WAIT);

  logic in_xfer, cfg_xfer, emit_now;
  assign in_xfer  = src_i.valid && src_i.ready;
  assign cfg_xfer = cfg_i.valid && cfg_i.ready;
  assign emit_now = (uw.op == OP_EMIT) && slot_free;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= P_WAIT;
      cnt_q       <= '0;
      si_q        <= '0;
      emitted_q   <= '0;
      run_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      src_ch_q    <= CH_W'(1);
      src_wide_q  <= 1'b1;
      tgt_ch_q    <= CH_W'(1);
      tgt_wide_q  <= 1'b1;
      src_rate_q  <= RATE_W'(44100);
      tgt_rate_q  <= RATE_W'(44100);
    end else begin
      pc_q <= pc_d;

      if (cfg_xfer) begin
        case (cfg_reg_e'(cfg_i.index))
          REG_SRC_CH:   src_ch_q   <= cfg_i.data[CH_W-1:0];
          REG_SRC_WIDE: src_wide_q <= cfg_i.data[0];
          REG_TGT_CH:   tgt_ch_q   <= cfg_i.data[CH_W-1:0];
          REG_TGT_WIDE: tgt_wide_q <= cfg_i.data[0];
          REG_SRC_RATE: src_rate_q <= cfg_i.data;
          REG_TGT_RATE: tgt_rate_q <= cfg_i.data;
          default: ;
        endcase
      end

      case (uw.op)
        OP_LOAD:     cnt_q <= CNTW'(RATE_W - 1);
        OP_MUL:      cnt_q <= cnt_q - CNTW'(1);
        OP_DIV_INIT: cnt_q <= CNTW'(XW - 1);
        OP_DIV:      cnt_q <= cnt_q - CNTW'(1);
        OP_RUN: begin
          // overflow outputs beyond the run cap still count as produced
          if (!run_none) begin
            emitted_q <= end_q;
          end
          run_cnt_q <= run_none ? '0 : run_n;
        end
        OP_EMIT: begin
          if (slot_free) begin
            run_cnt_q <= run_cnt_q - RUNW'(1);
          end
        end
        OP_DONE: begin
          if (last_q) begin
            si_q      <= '0;
            emitted_q <= '0;
          end else if (si_q != '1) begin
            si_q <= si_q + FRAME_COUNT_BITS'(1);
          end
        end
        default: ;
      endcase

      if (emit_now) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (uw.op)
      OP_LOAD: begin
        if (in_xfer) begin
          lo_q     <= lo_c;
          ro_q     <= ro_c;
          last_q   <= src_i.clip_end;
          acc_q    <= '0;
          mcand_q  <= XW'(si_q) + XW'(1);
          mplier_q <= orate;
        end
      end
      OP_MUL: begin
        // shift-add over the target rate bits
        if (mplier_q[0]) begin
          acc_q <= acc_q + mcand_q;
        end
        mcand_q  <= {mcand_q[XW-2:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[RATE_W-1:1]};
      end
      OP_DIV_INIT: rem_q <= '0;
      OP_DIV: begin
        rem_q <= ge ? RATE_W'(trial - {1'b0, irate}) : trial[RATE_W-1:0];
        acc_q <= {acc_q[XW-2:0], ge};
      end
      OP_END: end_q <= acc_q + XW'(inc);
      default: ;
    endcase

    if (emit_now) begin
      left_out_q  <= lo_q;
      right_out_q <= ro_q;
      run_last_q  <= (run_cnt_q == RUNW'(1));
      clip_last_q <= (run_cnt_q == RUNW'(1)) && last_q;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.left_out  = left_out_q;
  assign res_o.right_out = right_out_q;
  assign res_o.run_last  = run_last_q;
  assign res_o.clip_last = clip_last_q;

  // ------------------------------------------------------------- assertions
  a_emit_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pc_q == P_EMIT))
    else $error("output frame loaded outside the emit step");

  a_emit_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == P_EMIT) |-> (run_cnt_q != '0))
    else $error("emit step with an empty run");

  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == P_RUN) |=> (emitted_q >= $past(emitted_q)))
    else $error("emitted count went backward");

  a_clip_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && clip_last_q) |-> run_last_q)
    else $error("clip end frame not marked as end of run");

endmodule

@@ sim/pcm_format_converter_checker.sv @@
// ----------------------------------------------------------------------------
// pcm_format_converter_checker
// watches the register, frame and result channels, predicts every converted
// frame from its own copy of the settings and clip position, and compares
// ----------------------------------------------------------------------------
module pcm_format_converter_checker #(
  parameter int FRAME_COUNT_BITS = 32,
  parameter int MAX_RUN          = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  pcmfc_cfg_if cfg_i,
  pcmfc_in_if  src_i,
  pcmfc_out_if res_i,
  output int   backlog_o,
  output int   checked_o,
  output int   faults_o
);
  import pcmfc_pkg::*;

  localparam logic [CH_W-1:0]   CH_MONO       = 2'd1;
  localparam logic [RATE_W-1:0] RATE_AT_RESET = 19'd44100;
  localparam logic [63:0]       INDEX_CEIL    = (64'd1 << FRAME_COUNT_BITS) - 64'd1;
  localparam int                SHOWN_FAULTS  = 10;

  typedef struct packed {
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic                run_end;
    logic                clip_done;
  } pcm_frame_t;

  logic [CH_W-1:0]   src_ch;
  logic [CH_W-1:0]   tgt_ch;
  logic              src_wide;
  logic              tgt_wide;
  logic [RATE_W-1:0] src_rate;
  logic [RATE_W-1:0] tgt_rate;
  logic [63:0]       frame_idx;
  logic [63:0]       out_count;
  pcm_frame_t        due_frames[$];
  int                backlog = 0;
  int                checked = 0;
  int                faults  = 0;

  assign backlog_o = backlog;
  assign checked_o = checked;
  assign faults_o  = faults;

  // raw bits at source depth to raw bits at target depth
  function automatic logic [SAMPLE_W-1:0] requantize(logic [SAMPLE_W-1:0] v);
    int s;
    if (src_wide && !tgt_wide) begin
      s = int'($signed(v)) / 256 + 128;
      return {8'h00, s[7:0]};
    end
    if (!src_wide && tgt_wide) begin
      s = (int'(v[7:0]) - 128) * 256;
      return s[15:0];
    end
    return src_wide ? v : {8'h00, v[7:0]};
  endfunction

  function automatic void write_setting(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] value);
    case (cfg_reg_e'(idx))
      REG_SRC_CH:   src_ch   = value[CH_W-1:0];
      REG_SRC_WIDE: src_wide = value[0];
      REG_TGT_CH:   tgt_ch   = value[CH_W-1:0];
      REG_TGT_WIDE: tgt_wide = value[0];
      REG_SRC_RATE: src_rate = value;
      REG_TGT_RATE: tgt_rate = value;
      default: ;
    endcase
  endfunction

  // channel mix, depth change, then the output frames mapped to this input, up to MAX_RUN
  function automatic void convert_frame(logic [SAMPLE_W-1:0] l_raw, logic [SAMPLE_W-1:0] r_raw,
                                        logic fin);
    logic [SAMPLE_W-1:0] l;
    logic [SAMPLE_W-1:0] r;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] ro;
    logic                t_st;
    int                  mix;
    logic [63:0]         irate;
    logic [63:0]         orate;
    logic [63:0]         stop;
    logic [63:0]         cap;
    logic [63:0]         fsize;
    logic [63:0]         burst;
    t_st = (tgt_ch == CH_STEREO);
    l = src_wide ? l_raw : {8'h00, l_raw[7:0]};
    r = src_wide ? r_raw : {8'h00, r_raw[7:0]};
    if (src_ch != CH_STEREO) begin
      r = l;
    end else if (!t_st) begin
      if (src_wide) begin
        // signed average, truncated toward zero
        mix = (int'($signed(l)) + int'($signed(r))) / 2;
        l = mix[15:0];
      end else begin
        l = (l + r) >> 1;
      end
    end
    lo = requantize(l);
    ro = t_st ? requantize(r) : '0;

    irate = (src_rate == '0) ? 64'd1 : 64'(src_rate);
    orate = (tgt_rate == '0) ? 64'd1 : 64'(tgt_rate);
    stop  = ((frame_idx + 64'd1) * orate + irate - 64'd1) / irate;
    if (fin) begin
      fsize = (t_st ? 64'd2 : 64'd1) * (tgt_wide ? 64'd2 : 64'd1);
      cap = ((frame_idx + 64'd1) * fsize * orate + irate - 64'd1) / irate / fsize;
      if (cap < stop) stop = cap;
    end
    burst = (stop > out_count) ? stop - out_count : 64'd0;
    if (burst > 64'(MAX_RUN)) burst = 64'(MAX_RUN);
    if (stop > out_count) out_count = stop;
    for (int k = 0; k < int'(burst); k++) begin
      due_frames.push_back('{left: lo, right: ro, run_end: (k + 1 == int'(burst)),
                             clip_done: (fin && k + 1 == int'(burst))});
    end
    if (fin) begin
      frame_idx = '0;
      out_count = '0;
    end else if (frame_idx < INDEX_CEIL) begin
      frame_idx++;
    end
  endfunction

  function automatic void check_result(pcm_frame_t got);
    pcm_frame_t want;
    string      bad;
    checked++;
    if (due_frames.size() == 0) begin
      faults++;
      if (faults <= SHOWN_FAULTS)
        $display("[%0t] result with nothing expected: L=%h R=%h run_last=%b clip_last=%b",
                 $time, got.left, got.right, got.run_end, got.clip_done);
      return;
    end
    want = due_frames.pop_front();
    bad = "";
    if (got.left != want.left)           bad = {bad, " left_out"};
    if (got.right != want.right)         bad = {bad, " right_out"};
    if (got.run_end != want.run_end)     bad = {bad, " run_last"};
    if (got.clip_done != want.clip_done) bad = {bad, " clip_last"};
    if (bad != "") begin
      faults++;
      if (faults <= SHOWN_FAULTS)
        $display("[%0t] mismatch on%s: expected L=%h R=%h run_last=%b clip_last=%b, got L=%h R=%h run_last=%b clip_last=%b",
                 $time, bad, want.left, want.right, want.run_end, want.clip_done,
                 got.left, got.right, got.run_end, got.clip_done);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_ch    = CH_MONO;
      src_wide  = 1'b1;
      tgt_ch    = CH_MONO;
      tgt_wide  = 1'b1;
      src_rate  = RATE_AT_RESET;
      tgt_rate  = RATE_AT_RESET;
      frame_idx = '0;
      out_count = '0;
      due_frames.delete();
      backlog <= 0;
    end else begin
      // results first: a frame taken at this edge cannot have produced one yet
      if (res_i.valid && res_i.ready)
        check_result('{left: res_i.left_out, right: res_i.right_out, run_end: res_i.run_last,
                       clip_done: res_i.clip_last});
      if (cfg_i.valid && cfg_i.ready) write_setting(cfg_i.index, cfg_i.data);
      if (src_i.valid && src_i.ready) convert_frame(src_i.left_in, src_i.right_in, src_i.clip_end);
      backlog <= due_frames.size();
    end
  end

endmodule

@@ sim/pcm_format_converter_top_tb.sv @@
// ----------------------------------------------------------------------------
// pcm_format_converter_top_tb
// drives clips of pcm frames through the converter under many format and
// rate settings with random idling on both sides; the checker beside the
// block predicts and compares every result frame
// ----------------------------------------------------------------------------
module pcm_format_converter_top_tb;
  import pcmfc_pkg::*;

  localparam int FRAME_BITS     = 32;
  localparam int RUN_CAP        = 64;
  localparam int FRAME_TARGET   = 470;
  localparam int CALM_AFTER     = 430;
  localparam int SQUEEZE_AT     = 60;
  localparam int SQUEEZE_CYCLES = 400;
  // settling wait, sized for a frame of the block with a full run of results
  localparam int SETTLE_CYCLES  = FRAME_BITS + 44 + RUN_CAP;
  localparam int DRAIN_LIMIT    = 50000;
  localparam longint RUN_LIMIT  = 12_000_000;

  localparam logic [CH_W-1:0]   CH_MONO        = 2'd1;
  localparam logic [CH_W-1:0]   CH_NONE        = 2'd0;
  localparam logic [CH_W-1:0]   CH_SPARE       = 2'd3;
  localparam logic [RATE_W-1:0] RATE_TOP       = 19'd384000;
  localparam logic [RATE_W-1:0] RATE_FIELD_MAX = '1;

  logic clk_i;
  logic rst_ni;

  pcmfc_cfg_if cfg_if();
  pcmfc_in_if  src_if();
  pcmfc_out_if res_if();

  int   backlog;
  int   checked;
  int   faults;
  int   frames_sent  = 0;
  int   setups_used  = 0;
  int   idle_odds;
  logic calm;
  logic squeeze_req;

  pcm_format_converter_top #(
    .FRAME_COUNT_BITS(FRAME_BITS),
    .MAX_RUN         (RUN_CAP)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .src_i (src_if),
    .res_o (res_if)
  );

  pcm_format_converter_checker #(
    .FRAME_COUNT_BITS(FRAME_BITS),
    .MAX_RUN         (RUN_CAP)
  ) u_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_if),
    .src_i    (src_if),
    .res_i    (res_if),
    .backlog_o(backlog),
    .checked_o(checked),
    .faults_o (faults)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT);
    $display("FAIL");
    $finish;
  end

  // result side: random stall bursts, plus one long hold-off so the block
  // backs up and has to stall its frame input
  initial begin : result_drain
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (squeeze_req && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = SQUEEZE_CYCLES;
      end else if (stall_left == 0 && !calm && idle_odds != 0 &&
                   $urandom_range(1, idle_odds) == 1) begin
        stall_left = $urandom_range(1, 4);
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // one register transfer; valid stays up for a following write
  task automatic write_reg(cfg_reg_e idx, logic [RATE_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  // full format setting; noisy puts random bits above the narrow fields
  task automatic apply_setup(logic [CH_W-1:0] sch, logic sw, logic [CH_W-1:0] tch, logic tw,
                             logic [RATE_W-1:0] sr, logic [RATE_W-1:0] tr, logic noisy);
    logic [RATE_W-1:0] junk;
    junk = noisy ? RATE_W'($urandom) : '0;
    write_reg(REG_SRC_CH,   {junk[RATE_W-1:CH_W], sch});
    write_reg(REG_SRC_WIDE, {junk[RATE_W-1:1], sw});
    write_reg(REG_TGT_CH,   {junk[RATE_W-1:CH_W], tch});
    write_reg(REG_TGT_WIDE, {junk[RATE_W-1:1], tw});
    write_reg(REG_SRC_RATE, sr);
    write_reg(REG_TGT_RATE, tr);
    cfg_if.valid <= 1'b0;
    setups_used++;
  endtask

  // one frame transfer, sometimes after a short gap
  task automatic send_frame(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r, logic fin);
    if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      src_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    src_if.valid    <= 1'b1;
    src_if.left_in  <= l;
    src_if.right_in <= r;
    src_if.clip_end <= fin;
    do @(posedge clk_i); while (!src_if.ready);
    frames_sent++;
  endtask

  // wait until every predicted result is back, then let a frame that
  // produces nothing finish its pass through the sequencer
  task automatic settle();
    int guard;
    guard = 0;
    src_if.valid <= 1'b0;
    @(posedge clk_i);
    while (backlog != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      4:       return {8'($urandom), ($urandom_range(0, 1) ? 8'h80 : 8'h7F)};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CH_W-1:0] pick_channels();
    case ($urandom_range(0, 9))
      0:          return CH_NONE;
      1:          return CH_SPARE;
      2, 3, 4, 5: return CH_MONO;
      default:    return CH_STEREO;
    endcase
  endfunction

  // mostly common audio rates, some arbitrary, a few at the field extremes
  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return 19'd1;
      2:       return RATE_TOP;
      3:       return RATE_FIELD_MAX;
      4, 5, 6: return RATE_W'($urandom_range(1, 384000));
      7:       return 19'd8000;
      8:       return 19'd11025;
      9:       return 19'd16000;
      10:      return 19'd22050;
      11:      return 19'd32000;
      12:      return 19'd44100;
      13:      return 19'd48000;
      14:      return 19'd96000;
      default: return 19'd192000;
    endcase
  endfunction

  // a whole clip with random samples, end marker on the last frame
  task automatic run_clip(int len);
    for (int i = 0; i < len; i++) send_frame(pick_sample(), pick_sample(), i == len - 1);
  endtask

  initial begin : stimulus
    int phase_end;
    rst_ni          <= 1'b0;
    src_if.valid    <= 1'b0;
    src_if.left_in  <= '0;
    src_if.right_in <= '0;
    src_if.clip_end <= 1'b0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= REG_SRC_CH;
    cfg_if.data     <= '0;
    calm            <= 1'b0;
    squeeze_req     <= 1'b0;
    idle_odds       <= 4;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting, 16-bit mono straight through: sample extremes
    send_frame(16'h0000, 16'hFFFF, 1'b0);
    send_frame(16'hFFFF, 16'h0000, 1'b0);
    send_frame(16'h8000, 16'h1234, 1'b0);
    send_frame(16'h7FFF, 16'h8000, 1'b1);

    // 16-bit stereo averaged to 8-bit mono: truncation toward zero on
    // both the average and the divide by 256
    settle();
    apply_setup(CH_STEREO, 1'b1, CH_MONO, 1'b0, 19'd48000, 19'd48000, 1'b0);
    send_frame(16'hFFFF, 16'h0000, 1'b0);
    send_frame(16'h8000, 16'h8000, 1'b0);
    send_frame(16'h7FFF, 16'h7FFF, 1'b0);
    send_frame(16'hFF00, 16'hFEFF, 1'b1);

    // 8-bit stereo floor average to 16-bit mono, zero source rate acts as one
    settle();
    apply_setup(CH_STEREO, 1'b0, CH_MONO, 1'b1, '0, 19'd3, 1'b0);
    send_frame(16'h00FF, 16'h00FE, 1'b0);
    send_frame(16'hFF00, 16'hFF01, 1'b0);
    send_frame(16'hAB80, 16'h127F, 1'b1);

    // unused channel code as mono source, 8 to 16-bit stereo, run capped
    settle();
    apply_setup(CH_SPARE, 1'b0, CH_STEREO, 1'b1, 19'd1, RATE_TOP, 1'b1);
    send_frame(16'h5A80, 16'hFFFF, 1'b0);
    send_frame(16'h007F, 16'h0000, 1'b1);

    // zero channel code as mono, 8-bit stereo out, downsampling; the target
    // rate changes between frames of one clip and the end cap trims the tail
    settle();
    apply_setup(CH_NONE, 1'b0, CH_STEREO, 1'b0, 19'd7, 19'd2, 1'b1);
    send_frame(16'h0000, 16'h1111, 1'b0);
    send_frame(16'h00FF, 16'h2222, 1'b0);
    settle();
    write_reg(REG_TGT_RATE, 19'd5);
    cfg_if.valid <= 1'b0;
    send_frame(16'h0080, 16'h3333, 1'b1);

    // 16-bit stereo straight through where earlier frames already pass the
    // end cap, so the end frame gives nothing
    settle();
    apply_setup(CH_STEREO, 1'b1, CH_STEREO, 1'b1, 19'd10, 19'd3, 1'b0);
    send_frame(16'h8001, 16'h7FFE, 1'b0);
    send_frame(16'h4321, 16'hC0DE, 1'b1);

    // random settings, each phase a handful of complete clips
    while (frames_sent < FRAME_TARGET) begin
      settle();
      apply_setup(pick_channels(), 1'($urandom), pick_channels(), 1'($urandom), pick_rate(),
                  pick_rate(), 1'b1);
      idle_odds <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
      // the long hold-off lands inside a phase so frames keep coming
      if (frames_sent >= SQUEEZE_AT) squeeze_req <= 1'b1;
      phase_end = frames_sent + $urandom_range(20, 45);
      while (frames_sent < phase_end && frames_sent < FRAME_TARGET) begin
        // last stretch runs with no idling on either side
        if (frames_sent >= CALM_AFTER) calm <= 1'b1;
        run_clip(($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12));
      end
    end

    settle();
    $display("run covered %0d frames over %0d format settings, %0d result frames compared",
             frames_sent, setups_used, checked);
    $display("including sample extremes, clip end trimming, capped runs, zero rates and a %0d-cycle output hold-off",
             SQUEEZE_CYCLES);
    if (faults == 0 && backlog == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pcmfc_pkg.sv
rtl/pcmfc_if.sv
rtl/pcm_format_converter_top.sv
sim/pcm_format_converter_checker.sv
sim/pcm_format_converter_top_tb.sv
